// ===== src/b64c_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b64c_pkg: shared types and tables for the base64 codec
// alphabet lookups, status codes, queue entry layout
// ---------------------------------------------------------------------------
package b64c_pkg;

	localparam int MAX_DECODE_BYTES = 1024;
	localparam int LEN_W            = 11;
	localparam int QDEPTH           = 4;
	localparam int QPTR_W           = $clog2(QDEPTH);
	localparam int QCNT_W           = $clog2(QDEPTH + 1);

	localparam logic [LEN_W-1:0] EXP_CAP     = LEN_W'(MAX_DECODE_BYTES);
	localparam logic [LEN_W-1:0] EXP_RESET   = 11'd65;
	localparam logic [LEN_W-1:0] SEEN_MAX    = {LEN_W{1'b1}};
	// reciprocal of three for operands below 2048
	localparam logic [9:0]       RECIP3      = 10'd683;
	localparam logic [7:0]       CHAR_PAD    = 8'h3D;

	localparam logic REG_MODE    = 1'b0;
	localparam logic REG_EXP_LEN = 1'b1;

	localparam logic MODE_ENC = 1'b0;
	localparam logic MODE_DEC = 1'b1;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_BAD = 2'd1,
		ST_LEN = 2'd2
	} status_t;

	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      cnt;
		logic            has_data;
		logic            last;
		status_t         status;
	} entry_t;

	// 6-bit value to alphabet character
	function automatic logic [7:0] b64_char(input logic [5:0] v);
		logic [7:0] c;
		if (v < 6'd26) begin
			c = 8'd65 + {2'b00, v};
		end else if (v < 6'd52) begin
			c = 8'd97 + {2'b00, v} - 8'd26;
		end else if (v < 6'd62) begin
			c = 8'd48 + {2'b00, v} - 8'd52;
		end else if (v == 6'd62) begin
			c = 8'h2B;
		end else begin
			c = 8'h2F;
		end
		return c;
	endfunction

	// character to {in alphabet, 6-bit value}
	function automatic logic [6:0] b64_value(input logic [7:0] c);
		logic [6:0] r;
		if (c >= 8'd65 && c <= 8'd90) begin
			r = {1'b1, 6'(c - 8'd65)};
		end else if (c >= 8'd97 && c <= 8'd122) begin
			r = {1'b1, 6'(c - 8'd97 + 8'd26)};
		end else if (c >= 8'd48 && c <= 8'd57) begin
			r = {1'b1, 6'(c - 8'd48 + 8'd52)};
		end else if (c == 8'h2B) begin
			r = {1'b1, 6'd62};
		end else if (c == 8'h2F) begin
			r = {1'b1, 6'd63};
		end else begin
			r = 7'd0;
		end
		return r;
	endfunction

endpackage

// ===== src/b64c_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b64c_front: item intake and group assembly
// holds config and stream state, packs the results of each item into
// one queue entry
// ---------------------------------------------------------------------------
module b64c_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_idx,
	input  logic [10:0]      cfg_wdata,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       in_byte,
	input  logic             in_last,
	input  logic             q_full,
	output logic             push,
	output b64c_pkg::entry_t push_data
);
	import b64c_pkg::*;

	logic             mode_q;
	logic [LEN_W-1:0] exp_len_q;
	logic [1:0]       pos_q;
	logic [23:0]      acc_q;
	logic [LEN_W-1:0] emitted_q;
	logic [LEN_W-1:0] seen_q;
	logic             bad_q;

	logic             accept;
	logic [LEN_W-1:0] exp_c;
	logic [1:0]       enc_pos;
	logic [23:0]      enc_acc;
	logic             enc_emit;
	logic [6:0]       cv;
	logic             is_pad;
	logic             bad_now;
	logic [5:0]       dv;
	logic [23:0]      dec_acc;
	logic [LEN_W-1:0] rem;
	logic [1:0]       k;
	logic [LEN_W-1:0] emitted_new;
	logic [LEN_W-1:0] seen_new;
	logic [20:0]      prod;
	logic [11:0]      target;
	status_t          dec_st;
	entry_t           ent;
	logic             produce;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign exp_c    = (exp_len_q > EXP_CAP) ? EXP_CAP : exp_len_q;

	// encode path
	always_comb begin
		enc_pos = (pos_q == 2'd3) ? 2'd2 : pos_q;
		case (enc_pos)
			2'd0:    enc_acc = acc_q | {in_byte, 16'd0};
			2'd1:    enc_acc = acc_q | {8'd0, in_byte, 8'd0};
			default: enc_acc = acc_q | {16'd0, in_byte};
		endcase
		enc_emit = (enc_pos == 2'd2) || in_last;
	end

	// decode path
	always_comb begin
		cv      = b64_value(in_byte);
		is_pad  = (in_byte == CHAR_PAD) && pos_q[1];
		bad_now = !is_pad && !cv[6];
		dv      = (is_pad || !cv[6]) ? 6'd0 : cv[5:0];
		case (pos_q)
			2'd0:    dec_acc = acc_q | {dv, 18'd0};
			2'd1:    dec_acc = acc_q | {6'd0, dv, 12'd0};
			2'd2:    dec_acc = acc_q | {12'd0, dv, 6'd0};
			default: dec_acc = acc_q | {18'd0, dv};
		endcase
		rem = exp_c - emitted_q;
		if (pos_q != 2'd3 || emitted_q >= exp_c) begin
			k = 2'd0;
		end else if (rem >= 11'd3) begin
			k = 2'd3;
		end else begin
			k = rem[1:0];
		end
		emitted_new = emitted_q + {9'd0, k};
		seen_new    = (seen_q == SEEN_MAX) ? seen_q : seen_q + 11'd1;
		prod        = 21'(exp_c + 11'd2) * 21'(RECIP3);
		target      = {prod[20:11], 2'b00};
		if (({1'b0, seen_new} != target) || (emitted_new != exp_c)) begin
			dec_st = ST_LEN;
		end else if (bad_q || bad_now) begin
			dec_st = ST_BAD;
		end else begin
			dec_st = ST_OK;
		end
	end

	// entry assembly
	always_comb begin
		ent = '0;
		if (mode_q == MODE_ENC) begin
			produce        = enc_emit;
			ent.bytes[0]   = b64_char(enc_acc[23:18]);
			ent.bytes[1]   = b64_char(enc_acc[17:12]);
			ent.bytes[2]   = (enc_pos != 2'd0) ? b64_char(enc_acc[11:6]) : CHAR_PAD;
			ent.bytes[3]   = (enc_pos == 2'd2) ? b64_char(enc_acc[5:0]) : CHAR_PAD;
			ent.cnt        = 2'd3;
			ent.has_data   = 1'b1;
			ent.last       = in_last;
			ent.status     = ST_OK;
		end else begin
			produce        = (k != 2'd0) || in_last;
			ent.last       = in_last;
			ent.status     = in_last ? dec_st : ST_OK;
			if (k != 2'd0) begin
				ent.bytes[0] = dec_acc[23:16];
				ent.bytes[1] = dec_acc[15:8];
				ent.bytes[2] = dec_acc[7:0];
				ent.cnt      = k - 2'd1;
				ent.has_data = 1'b1;
			end
		end
	end

	assign push      = accept && produce;
	assign push_data = ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_ENC;
			exp_len_q <= EXP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MODE:    mode_q    <= cfg_wdata[0];
				REG_EXP_LEN: exp_len_q <= cfg_wdata;
				default:     mode_q    <= mode_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= 2'd0;
			acc_q     <= '0;
			emitted_q <= '0;
			seen_q    <= '0;
			bad_q     <= 1'b0;
		end else if (accept) begin
			if (in_last) begin
				pos_q     <= 2'd0;
				acc_q     <= '0;
				emitted_q <= '0;
				seen_q    <= '0;
				bad_q     <= 1'b0;
			end else if (mode_q == MODE_ENC) begin
				pos_q <= enc_emit ? 2'd0 : enc_pos + 2'd1;
				acc_q <= enc_emit ? 24'd0 : enc_acc;
			end else begin
				pos_q     <= pos_q + 2'd1;
				acc_q     <= (pos_q == 2'd3) ? 24'd0 : dec_acc;
				emitted_q <= emitted_new;
				seen_q    <= seen_new;
				bad_q     <= bad_q || bad_now;
			end
		end
	end

	// no decoded byte beyond the expected length
	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && mode_q == MODE_DEC && emitted_q <= exp_c) |-> (emitted_new <= exp_c))
		else $error("decoded byte count overruns expected length");

endmodule

// ===== src/b64c_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b64c_queue: entry queue between intake and emission
// small circular buffer of result groups
// ---------------------------------------------------------------------------
module b64c_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  b64c_pkg::entry_t push_data,
	output logic             full,
	output logic             nonempty,
	input  logic             pop,
	output b64c_pkg::entry_t pop_data
);
	import b64c_pkg::*;

	entry_t            slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full     = (cnt_q == QCNT_W'(QDEPTH));
	assign nonempty = (cnt_q != '0);
	assign pop_data = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!nonempty |-> !pop)
		else $error("pop from an empty queue");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + QCNT_W'(1)))
		else $error("queue count did not follow a push");

endmodule

// ===== src/b64c_emit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b64c_emit: result emission
// unpacks one queue entry into up to four result items; absent an out_ready stall, one per cycle
// ---------------------------------------------------------------------------
module b64c_emit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_nonempty,
	input  b64c_pkg::entry_t q_data,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       out_byte,
	output logic             has_data,
	output logic             out_last,
	output logic [1:0]       status
);
	import b64c_pkg::*;

	entry_t     cur_q;
	logic       cur_v_q;
	logic [1:0] idx_q;

	logic fire;
	logic at_end;
	logic done;

	assign fire   = cur_v_q && out_ready;
	assign at_end = (idx_q == cur_q.cnt);
	assign done   = fire && at_end;
	assign q_pop  = q_nonempty && (!cur_v_q || done);

	assign out_valid = cur_v_q;
	assign out_byte  = cur_q.bytes[idx_q];
	assign has_data  = cur_q.has_data;
	assign out_last  = at_end && cur_q.last;
	assign status    = (at_end && cur_q.last) ? cur_q.status : ST_OK;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (q_pop) begin
			cur_v_q <= 1'b1;
			idx_q   <= 2'd0;
		end else if (done) begin
			cur_v_q <= 1'b0;
		end else if (fire) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	// status-only items close a stream
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != ST_OK || !has_data)) |-> out_last)
		else $error("status or empty item away from stream end");

	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cur_v_q |-> (idx_q <= cur_q.cnt))
		else $error("item index past entry count");

endmodule

// ===== src/base64_stream_codec.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// base64_stream_codec: streaming base64 encoder and decoder
// standard alphabet with '=' padding, length check and status on decode
//
//  channel | signals                                 | handshake
//  --------+-----------------------------------------+-----------------
//  input   | in_byte, in_last                        | in_valid/in_ready
//  output  | out_byte, has_data, out_last, status    | out_valid/out_ready
//  config  | cfg_idx, cfg_wdata                      | cfg_we, no wait
//
// one input item is taken per cycle while the four-entry group queue has room
// each item yields at most one queue entry of up to four result items, and the
// output side sends one result item per cycle unless out_ready stalls it, so
// encode throughput is set by the output port and decode throughput by the
// input port
// reset clears config to encode and length 65 and empties the queue at once
// a stalled output fills the queue, after which in_ready drops
// ---------------------------------------------------------------------------
module base64_stream_codec (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [10:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        has_data,
	output logic        out_last,
	output logic [1:0]  status
);
	import b64c_pkg::*;

	logic   push;
	entry_t push_data;
	logic   q_full;
	logic   q_nonempty;
	logic   q_pop;
	entry_t q_data;

	b64c_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	b64c_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.nonempty  (q_nonempty),
		.pop       (q_pop),
		.pop_data  (q_data)
	);

	b64c_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_data     (q_data),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.has_data   (has_data),
		.out_last   (out_last),
		.status     (status)
	);

endmodule
